FILE: hdl/urf_pkg.sv
// Package for the ultrasonic range filter: beat types, register map and constants.
// No dependencies; every other file of the block imports it.
package urf_pkg;

    localparam int unsigned EchoW   = 14;
    localparam int unsigned DtInW   = 20;
    localparam int unsigned DistW   = 16;
    localparam int unsigned TauW    = 20;
    localparam int unsigned FiltW   = 24;
    localparam int unsigned DtW     = 19;
    localparam int unsigned DenomW  = TauW + 1;
    localparam int unsigned ScaleW  = 13;
    localparam int unsigned ConvW   = EchoW + ScaleW;
    localparam int unsigned EchoShift = 10;
    localparam int unsigned ProdW   = DtW + FiltW;
    localparam int unsigned DivSteps = FiltW;
    localparam int unsigned CntW    = $clog2(DivSteps);

    localparam logic [ScaleW-1:0] EchoScale   = ScaleW'(4457);
    localparam logic [DtInW-1:0]  DtLimitUs   = DtInW'(500000);
    localparam logic [DtW-1:0]    DtDefaultUs = DtW'(1000);

    localparam int unsigned PaddrW = 4;
    localparam int unsigned PdataW = 32;

    localparam logic [1:0] RegTimeConst = 2'd0;
    localparam logic [1:0] RegMaxDist   = 2'd1;
    localparam logic [1:0] RegMinDist   = 2'd2;

    localparam logic [TauW-1:0]  TauReset     = TauW'(100000);
    localparam logic [DistW-1:0] MaxDistReset = DistW'(25600);
    localparam logic [DistW-1:0] MinDistReset = DistW'(768);

    typedef struct packed {
        logic [EchoW-1:0] echo_us;
        logic [DtInW-1:0] elapsed_us;
    } t_in_beat;

    typedef struct packed {
        logic [DistW-1:0] raw_distance;
        logic [DistW-1:0] filtered_distance;
        logic             reading_fresh;
    } t_out_beat;

endpackage

FILE: hdl/urf_ifs.sv
// Valid/ready channel interfaces for the measurement input and the range output.
// Depends on urf_pkg for the beat types.
interface urf_in_if;
    import urf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface urf_out_if;
    import urf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_beat payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/ultrasonic_range_filter.sv
// Each measurement beat runs through these steps in order, from acceptance to its result:
// latch, convert and gate the echo, form the filter error, multiply, run a restoring
// divider that yields one quotient bit per cycle, and update the filter. The input is
// ready only while the sequencer is idle. A finished result waits in an output register,
// so the next measurement may enter before it is taken.
// Depends on urf_pkg and the channel interfaces in urf_ifs.sv.
module ultrasonic_range_filter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    urf_in_if.sink                       i_meas,
    urf_out_if.source                    o_range,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [urf_pkg::PaddrW-1:0]   paddr,
    input  logic [urf_pkg::PdataW-1:0]   pwdata,
    output logic [urf_pkg::PdataW-1:0]   prdata,
    output logic                         pready
);
    import urf_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CONV = 6'b000010,
        S_DIFF = 6'b000100,
        S_MUL  = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state            r_state;
    logic [TauW-1:0]   r_tau;
    logic [DistW-1:0]  r_max;
    logic [DistW-1:0]  r_min;

    logic [EchoW-1:0]  r_echo;
    logic [DtInW-1:0]  r_elapsed;
    logic [DistW-1:0]  r_held;
    logic              r_fresh;
    logic [FiltW-1:0]  r_filter;
    logic              r_up;
    logic              r_dt_zero;
    logic [DtW-1:0]    r_dt;
    logic [FiltW-1:0]  r_mag;
    logic [DenomW-1:0] r_denom;
    logic [DenomW-1:0] r_rem;
    logic [FiltW-1:0]  r_quo;
    logic [CntW-1:0]   r_cnt;
    logic              r_out_valid;
    t_out_beat         r_out;

    logic [ConvW-1:0]  n_conv;
    logic [ConvW-EchoShift-1:0] n_dist;
    logic              n_accept;
    logic [FiltW-1:0]  n_target;
    logic [DtW-1:0]    n_dt;
    logic [ProdW-1:0]  n_prod;
    logic [DenomW:0]   n_trial;
    logic              n_ge;
    logic [FiltW-1:0]  n_step;
    logic [FiltW-1:0]  n_filter;
    logic              n_leave;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[3:2])
            RegTimeConst: prdata = PdataW'(r_tau);
            RegMaxDist:   prdata = PdataW'(r_max);
            RegMinDist:   prdata = PdataW'(r_min);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tau <= TauReset;
            r_max <= MaxDistReset;
            r_min <= MinDistReset;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                RegTimeConst: r_tau <= pwdata[TauW-1:0];
                RegMaxDist:   r_max <= pwdata[DistW-1:0];
                RegMinDist:   r_min <= pwdata[DistW-1:0];
                default: begin
                end
            endcase
        end
    end

    assign i_meas.ready    = (r_state == S_IDLE);
    assign o_range.valid   = r_out_valid;
    assign o_range.payload = r_out;

    always_comb begin
        n_conv   = ConvW'(r_echo) * ConvW'(EchoScale);
        n_dist   = n_conv[ConvW-1:EchoShift];
        n_accept = (r_echo != '0) && (n_dist <= (ConvW-EchoShift)'(r_max))
                   && (n_dist > (ConvW-EchoShift)'(r_min));
        n_target = {r_held, 8'd0};
        n_dt     = (r_elapsed > DtLimitUs) ? DtDefaultUs : r_elapsed[DtW-1:0];
        n_prod   = ProdW'(r_dt) * ProdW'(r_mag);
        n_trial  = {r_rem, r_quo[FiltW-1]};
        n_ge     = n_trial >= (DenomW+1)'(r_denom);
        n_step   = r_dt_zero ? '0 : r_quo;
        n_filter = r_up ? (r_filter + n_step) : (r_filter - n_step);
        n_leave  = !r_out_valid || o_range.ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_filter    <= '0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            if (r_state == S_DONE && n_leave) begin
                r_out_valid <= 1'b1;
            end else if (o_range.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_meas.valid) begin
                        r_echo    <= i_meas.payload.echo_us;
                        r_elapsed <= i_meas.payload.elapsed_us;
                        r_state   <= S_CONV;
                    end
                end
                S_CONV: begin
                    r_fresh <= n_accept;
                    if (n_accept) begin
                        r_held <= n_dist[DistW-1:0];
                    end
                    r_state <= S_DIFF;
                end
                S_DIFF: begin
                    r_up      <= n_target >= r_filter;
                    r_mag     <= (n_target >= r_filter) ? (n_target - r_filter)
                                                        : (r_filter - n_target);
                    r_dt      <= n_dt;
                    r_dt_zero <= (n_dt == '0);
                    r_denom   <= DenomW'(r_tau) + DenomW'(n_dt);
                    r_state   <= S_MUL;
                end
                S_MUL: begin
                    r_rem   <= DenomW'(n_prod[ProdW-1:FiltW]);
                    r_quo   <= n_prod[FiltW-1:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem <= n_ge ? DenomW'(n_trial - (DenomW+1)'(r_denom))
                                  : n_trial[DenomW-1:0];
                    r_quo <= {r_quo[FiltW-2:0], n_ge};
                    r_cnt <= r_cnt + CntW'(1);
                    if (r_cnt == CntW'(DivSteps - 1)) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (n_leave) begin
                        r_filter                <= n_filter;
                        r_out.raw_distance      <= r_held;
                        r_out.filtered_distance <= n_filter[FiltW-1:8];
                        r_out.reading_fresh     <= r_fresh;
                        r_state                 <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("sequencer state is not one-hot");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_meas.valid && i_meas.ready) |=> (r_state == S_CONV))
        else $error("accepted beat did not start conversion");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && !r_dt_zero) |-> (r_rem < r_denom))
        else $error("divider remainder reached the divisor");

    a_filter_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_DONE) |=> $stable(r_filter))
        else $error("filter state changed outside the update step");

endmodule

FILE: tb/sv/tb_ultrasonic_range_filter.sv
`timescale 1ns / 100ps
// Self-checking testbench for ultrasonic_range_filter: directed table, then random
// measurements under varying handshake pressure, checked against an in-line predictor.
// Depends on urf_pkg, the channel interfaces in urf_ifs.sv and the block itself.
module tb_ultrasonic_range_filter;
    import urf_pkg::*;

    localparam int unsigned CycleLimit = 1000000;
    localparam int unsigned BlockItems = 150;

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic [1:0]       reg_idx;
        logic [31:0]      reg_val;
        logic [EchoW-1:0] echo;
        logic [DtInW-1:0] elapsed;
        bit               typed;
        t_out_beat        want;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PaddrW-1:0] paddr;
    logic [PdataW-1:0] pwdata;
    logic [PdataW-1:0] prdata;
    logic pready;

    urf_in_if  meas_if ();
    urf_out_if range_if ();

    ultrasonic_range_filter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_meas  (meas_if.sink),
        .o_range (range_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [TauW-1:0]  tau_q;
    logic [DistW-1:0] max_q;
    logic [DistW-1:0] min_q;
    logic [DistW-1:0] held_q;
    logic [FiltW-1:0] filt_q;

    t_out_beat   pending_ranges[$];
    t_row        directed[$];
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    int unsigned stall_left;

    always #5 i_clk = ~i_clk;

    function automatic t_out_beat predict_range(input logic [EchoW-1:0] echo,
                                                input logic [DtInW-1:0] elapsed);
        logic [31:0]      distance;
        logic [DtInW-1:0] dt;
        logic [63:0]      denom;
        logic [63:0]      mag;
        logic [63:0]      step;
        logic [FiltW-1:0] target;
        t_out_beat        res;
        res.reading_fresh = 1'b0;
        distance = (32'(echo) * 32'(EchoScale)) >> EchoShift;
        if (echo != '0 && distance <= 32'(max_q) && distance > 32'(min_q)) begin
            held_q = distance[DistW-1:0];
            res.reading_fresh = 1'b1;
        end
        dt = (elapsed > DtLimitUs) ? DtInW'(DtDefaultUs) : elapsed;
        denom = 64'(tau_q) + 64'(dt);
        target = {held_q, 8'h00};
        if (denom != 0 && dt != 0) begin
            if (target >= filt_q) begin
                mag = 64'(target - filt_q);
                step = (64'(dt) * mag) / denom;
                filt_q = filt_q + step[FiltW-1:0];
            end else begin
                mag = 64'(filt_q - target);
                step = (64'(dt) * mag) / denom;
                filt_q = filt_q - step[FiltW-1:0];
            end
        end
        res.raw_distance = held_q;
        res.filtered_distance = filt_q[FiltW-1:8];
        return res;
    endfunction

    function automatic logic [31:0] reg_mask(input logic [1:0] idx);
        case (idx)
            RegTimeConst: return 32'(1 << TauW) - 1;
            RegMaxDist,
            RegMinDist:   return 32'(1 << DistW) - 1;
            default:      return '0;
        endcase
    endfunction

    function automatic t_row item_row(input int unsigned echo, input int unsigned elapsed);
        t_row r;
        r.kind = ROW_ITEM;
        r.reg_idx = '0;
        r.reg_val = '0;
        r.echo = EchoW'(echo);
        r.elapsed = DtInW'(elapsed);
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    function automatic t_row typed_row(input int unsigned echo, input int unsigned elapsed,
                                       input int unsigned raw, input int unsigned filt,
                                       input bit fresh);
        t_row r;
        r = item_row(echo, elapsed);
        r.typed = 1'b1;
        r.want.raw_distance = DistW'(raw);
        r.want.filtered_distance = DistW'(filt);
        r.want.reading_fresh = fresh;
        return r;
    endfunction

    function automatic t_row reg_row(input logic [1:0] idx, input int unsigned val);
        t_row r;
        r = item_row(0, 0);
        r.kind = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = 32'(val);
        return r;
    endfunction

    // All tasks below are entered and left at a falling clock edge.
    task automatic send_measurement(input logic [EchoW-1:0] echo,
                                    input logic [DtInW-1:0] elapsed);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            meas_if.valid = 1'b0;
            repeat ($urandom_range(1, 48)) @(negedge i_clk);
        end
        meas_if.payload.echo_us = echo;
        meas_if.payload.elapsed_us = elapsed;
        meas_if.valid = 1'b1;
        do @(posedge i_clk); while (!meas_if.ready);
        pending_ranges.push_back(predict_range(echo, elapsed));
        @(negedge i_clk);
    endtask

    task automatic drain_ranges();
        meas_if.valid = 1'b0;
        while (pending_ranges.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        logic [31:0] got;
        mask = reg_mask(idx);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = PaddrW'({idx, 2'b00});
        pwdata = (val & mask) | ($urandom & ~mask);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            RegTimeConst: tau_q = val[TauW-1:0];
            RegMaxDist:   max_q = val[DistW-1:0];
            RegMinDist:   min_q = val[DistW-1:0];
            default:      ;
        endcase
        @(negedge i_clk);
        penable = 1'b0;
        pwrite = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        if (got !== (val & mask)) begin
            mismatches++;
            $display("%0t: register %0d readback expected %0d actual %0d",
                     $time, idx, val & mask, got);
        end
    endtask

    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            range_if.ready <= 1'b0;
        end else if (recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct) begin
            stall_left <= $urandom_range(15);
            range_if.ready <= 1'b0;
        end else begin
            range_if.ready <= 1'b1;
        end
    end

    // Every output beat is checked against the oldest predicted range.
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && range_if.valid && range_if.ready) begin
            if (pending_ranges.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected range beat, expected none actual raw %0d",
                         $time, range_if.payload.raw_distance);
            end else begin
                want = pending_ranges.pop_front();
                if (range_if.payload.raw_distance !== want.raw_distance
                        || range_if.payload.filtered_distance !== want.filtered_distance
                        || range_if.payload.reading_fresh !== want.reading_fresh) begin
                    mismatches++;
                    $display({"%0t: expected raw %0d filt %0d fresh %0d,",
                              " actual raw %0d filt %0d fresh %0d"},
                             $time, want.raw_distance, want.filtered_distance,
                             want.reading_fresh, range_if.payload.raw_distance,
                             range_if.payload.filtered_distance,
                             range_if.payload.reading_fresh);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CycleLimit) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned      phase;
        int unsigned      blk;
        int unsigned      n;
        int unsigned      lo;
        int unsigned      hi;
        logic [EchoW-1:0] echo;
        logic [DtInW-1:0] elapsed;
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        meas_if.valid = 1'b0;
        meas_if.payload = '0;
        range_if.ready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        stall_left = 0;
        tau_q = TauReset;
        max_q = MaxDistReset;
        min_q = MinDistReset;
        held_q = '0;
        filt_q = '0;

        directed.push_back(typed_row(0, 0, 0, 0, 1'b0));
        directed.push_back(typed_row(0, 1000, 0, 0, 1'b0));
        directed.push_back(typed_row(10000, 0, 0, 0, 1'b0));
        directed.push_back(item_row(176, 1000));
        directed.push_back(item_row(177, 1000));
        directed.push_back(item_row(5881, 500000));
        directed.push_back(item_row(5882, 500001));
        directed.push_back(item_row(16383, 1048575));
        directed.push_back(item_row(10000, 0));
        directed.push_back(reg_row(RegTimeConst, 0));
        directed.push_back(typed_row(1000, 1, 4352, 4352, 1'b1));
        directed.push_back(typed_row(0, 0, 4352, 4352, 1'b0));
        directed.push_back(typed_row(16383, 600000, 4352, 4352, 1'b0));
        directed.push_back(reg_row(RegMaxDist, 25601));
        directed.push_back(reg_row(RegMinDist, 25597));
        directed.push_back(typed_row(5882, 1, 25601, 25601, 1'b1));
        directed.push_back(typed_row(5881, 1, 25601, 25601, 1'b0));
        directed.push_back(reg_row(RegMinDist, 65535));
        directed.push_back(typed_row(5000, 7, 25601, 25601, 1'b0));
        directed.push_back(reg_row(RegTimeConst, 1048575));
        directed.push_back(reg_row(RegMaxDist, 65535));
        directed.push_back(reg_row(RegMinDist, 0));
        directed.push_back(item_row(1, 500000));
        directed.push_back(item_row(15056, 1000));
        directed.push_back(item_row(15057, 1000));
        directed.push_back(item_row(0, 1048575));
        directed.push_back(reg_row(RegTimeConst, 1));
        directed.push_back(item_row(14706, 999));
        directed.push_back(reg_row(RegTimeConst, 100000));
        directed.push_back(reg_row(RegMaxDist, 25600));
        directed.push_back(reg_row(RegMinDist, 768));

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[i]) begin
            if (directed[i].kind == ROW_REG) begin
                drain_ranges();
                write_register(directed[i].reg_idx, directed[i].reg_val);
            end else begin
                send_measurement(directed[i].echo, directed[i].elapsed);
                if (directed[i].typed) begin
                    pending_ranges[pending_ranges.size() - 1] = directed[i].want;
                end
            end
        end

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 35; recv_stall_pct = 35; end
            endcase
            for (blk = 0; blk < 3; blk++) begin
                drain_ranges();
                case ($urandom_range(7))
                    0: write_register(RegTimeConst, 0);
                    1: write_register(RegTimeConst, 1);
                    2: write_register(RegTimeConst, $urandom_range(2, 1000));
                    3: write_register(RegTimeConst, $urandom_range(1000, 200000));
                    4: write_register(RegTimeConst, 1000000);
                    5: write_register(RegTimeConst, 32'(1 << TauW) - 1);
                    default: write_register(RegTimeConst, $urandom_range(1, 1000000));
                endcase
                case ($urandom_range(5))
                    0: begin lo = MinDistReset; hi = MaxDistReset; end
                    1: begin lo = 0; hi = 65535; end
                    2: begin
                        hi = $urandom_range(0, 65535);
                        lo = $urandom_range(hi, 65535);
                    end
                    default: begin
                        lo = $urandom_range(0, 4000);
                        hi = $urandom_range(lo, 65535);
                    end
                endcase
                write_register(RegMaxDist, hi);
                write_register(RegMinDist, lo);
                for (n = 0; n < BlockItems; n++) begin
                    case ($urandom_range(9))
                        0: echo = '0;
                        1: echo = EchoW'($urandom_range(10001, 16383));
                        2: echo = EchoW'($urandom_range(170, 185));
                        3: echo = EchoW'($urandom_range(5870, 5895));
                        default: echo = EchoW'($urandom_range(1, 10000));
                    endcase
                    case ($urandom_range(9))
                        0: elapsed = '0;
                        1: elapsed = DtInW'($urandom_range(499999, 500002));
                        2: elapsed = DtInW'($urandom_range(0, (1 << DtInW) - 1));
                        3: elapsed = DtInW'($urandom_range(1, 100));
                        default: elapsed = DtInW'($urandom_range(1000, 100000));
                    endcase
                    send_measurement(echo, elapsed);
                end
            end
        end

        drain_ranges();
        repeat (40) @(posedge i_clk);
        if (mismatches == 0 && pending_ranges.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
